/* design/fcs_pkg.sv */
// Shared types, constants and helpers for the ISO 8473 Fletcher checksum block.
// No dependencies; the front end, back end and top level import this package.
package fcs_pkg;

    localparam int FCS_LENGTH_BITS = 16;
    localparam int FCS_MID_DEPTH   = 2;
    localparam int FCS_OUT_DEPTH   = 8;

    localparam logic [8:0] MOD_VALUE   = 9'd255;
    localparam logic [7:0] MOD_TOP     = 8'd254;
    localparam logic [7:0] X_ZERO_CODE = 8'hFF;
    localparam logic [7:0] Y_ZERO_CODE = 8'h01;

    // Sums and flags of one finished PDU, handed from the front to the back.
    typedef struct packed {
        logic [7:0] run_a;
        logic [7:0] run_b;
        logic [7:0] gen_a;
        logic [7:0] gen_b;
        logic       pos_err;
    } t_sums;

    // One result item as it sits in the output queue.
    typedef struct packed {
        logic [7:0]  verify_sum_a;
        logic [7:0]  verify_sum_b;
        logic        verify_ok;
        logic [15:0] check_value;
        logic        position_error;
    } t_result;

    // Mod-255 add of two values that are each below 256 (sum at most 510).
    function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        mod_add = (s >= MOD_VALUE) ? 8'(s - MOD_VALUE) : s[7:0];
    endfunction

endpackage

/* design/fcs_fifo.sv */
// Small first-in first-out queue built from flip-flops, one read pointer.
// Used between the front and back and as the output queue; no package needed.
module fcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

/* design/fcs_front.sv */
// Front end: takes PDU bytes, keeps the running verify and generate sums.
// Depends on fcs_pkg; on the last byte it emits one record for the back end.
module fcs_front import fcs_pkg::*; #(
    parameter int LENGTH_BITS = FCS_LENGTH_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_byte,
    input  logic                   i_last_byte,
    input  logic [15:0]            i_check_position,
    output logic                   o_rec_push,
    output t_sums                  o_rec_sums,
    output logic [LENGTH_BITS-1:0] o_rec_span
);
    // Compare width holds both the count and position + 2.
    localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [7:0]             r_run_a, r_run_b, r_gen_a, r_gen_b;
    logic [LENGTH_BITS-1:0] r_count;
    logic [15:0]            r_pos;

    logic [7:0]             base_run_a, base_run_b, base_gen_a, base_gen_b;
    logic [LENGTH_BITS-1:0] base_count;
    logic [15:0]            pos;
    logic [7:0]             n_run_a, n_run_b, n_gen_a, n_gen_b;
    logic [LENGTH_BITS-1:0] n_count;
    logic [CW-1:0]          ext_count, ext_pos, ext_len;
    logic                   in_field;

    always_comb begin
        base_run_a = i_first_byte ? 8'd0 : r_run_a;
        base_run_b = i_first_byte ? 8'd0 : r_run_b;
        base_gen_a = i_first_byte ? 8'd0 : r_gen_a;
        base_gen_b = i_first_byte ? 8'd0 : r_gen_b;
        base_count = i_first_byte ? '0 : r_count;
        pos        = i_first_byte ? i_check_position : r_pos;

        ext_count = CW'(base_count);
        ext_pos   = CW'(pos);
        // The two checksum bytes count as zero in the generate sums.
        in_field  = (ext_count == ext_pos) || (ext_count == ext_pos + 1'b1);

        n_run_a = mod_add(base_run_a, i_data_byte);
        n_run_b = mod_add(base_run_b, n_run_a);
        n_gen_a = in_field ? base_gen_a : mod_add(base_gen_a, i_data_byte);
        n_gen_b = mod_add(base_gen_b, n_gen_a);
        n_count = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
        ext_len = CW'(n_count);
    end

    assign o_rec_push         = i_accept && i_last_byte;
    assign o_rec_sums.run_a   = n_run_a;
    assign o_rec_sums.run_b   = n_run_b;
    assign o_rec_sums.gen_a   = n_gen_a;
    assign o_rec_sums.gen_b   = n_gen_b;
    assign o_rec_sums.pos_err = (ext_pos + CW'(2)) > ext_len;
    // Only meaningful when the field fits, and then it fits in LENGTH_BITS.
    assign o_rec_span         = LENGTH_BITS'(ext_len - ext_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_a <= '0;
            r_run_b <= '0;
            r_gen_a <= '0;
            r_gen_b <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_run_a <= n_run_a;
            r_run_b <= n_run_b;
            r_gen_a <= n_gen_a;
            r_gen_b <= n_gen_b;
            r_count <= n_count;
            r_pos   <= pos;
        end
    end
endmodule

/* design/fcs_back.sv */
// Back end: turns one PDU record into a result item in a two-stage pipeline.
// Depends on fcs_pkg; stage one multiplies, stage two folds mod 255.
module fcs_back import fcs_pkg::*; #(
    parameter int LENGTH_BITS = FCS_LENGTH_BITS,
    parameter int OUT_DEPTH   = FCS_OUT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rec_valid,
    input  t_sums                      i_rec_sums,
    input  logic [LENGTH_BITS-1:0]     i_rec_span,
    output logic                       o_rec_pop,
    input  logic [$clog2(OUT_DEPTH):0] i_out_count,
    output logic                       o_res_valid,
    output t_result                    o_res
);
    localparam int FW = LENGTH_BITS + 8;
    localparam int NB = (FW + 7) / 8;
    localparam int PW = NB * 8;
    localparam int SW = 8 + $clog2(NB + 1);
    localparam int OCW = $clog2(OUT_DEPTH) + 1;
    localparam int ACW = OCW + 1;

    // Stage one: product (length - position) * A.
    logic          r_s1_v;
    t_sums         r_s1_sums;
    logic [FW-1:0] r_s1_f;
    // Stage two: byte fold of the product and the sign decisions.
    logic          r_s2_v;
    t_sums         r_s2_sums;
    logic [SW-1:0] r_s2_fold;
    logic [7:0]    r_s2_cx, r_s2_cy;
    logic          r_s2_xneg, r_s2_ypos;

    logic          load;
    logic [ACW-1:0] used;
    logic [PW-1:0] fpad;
    logic [SW-1:0] fold;
    logic [8:0]    ab;
    logic [8:0]    v;
    logic [7:0]    r255, m, n, xb, yb;

    // Results in flight plus queued must fit in the output queue.
    assign used      = ACW'(i_out_count) + ACW'(r_s1_v) + ACW'(r_s2_v);
    assign load      = i_rec_valid && (used < ACW'(OUT_DEPTH));
    assign o_rec_pop = load;

    always_comb begin
        fpad = PW'(r_s1_f);
        fold = '0;
        for (int k = 0; k < NB; k++) begin
            fold = fold + SW'(fpad[k*8 +: 8]);
        end
        ab = {1'b0, r_s1_sums.gen_a} + {1'b0, r_s1_sums.gen_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= load;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sums <= i_rec_sums;
        r_s1_f    <= FW'(i_rec_span) * FW'(i_rec_sums.gen_a);
        r_s2_sums <= r_s1_sums;
        r_s2_fold <= fold;
        r_s2_cx   <= mod_add(r_s1_sums.gen_a, r_s1_sums.gen_b);
        r_s2_cy   <= (r_s1_sums.gen_b == 8'd0) ? MOD_TOP : r_s1_sums.gen_b - 8'd1;
        r_s2_xneg <= r_s1_f < FW'(ab);
        r_s2_ypos <= (r_s1_sums.gen_b != 8'd0) && (r_s1_f < FW'(r_s1_sums.gen_b - 8'd1));
    end

    // M = (f - A - B) mod 255 and N = (B - 1 - f) mod 255, both 0..254.
    // The one's-complement step and the truncated remainder then become
    // small substitutions on M and N.
    always_comb begin
        v    = 9'(r_s2_fold[7:0]) + 9'(r_s2_fold[SW-1:8]);
        r255 = (v >= MOD_VALUE) ? 8'(v - MOD_VALUE) : v[7:0];
        m    = (r255 >= r_s2_cx) ? r255 - r_s2_cx : 8'(9'(r255) + MOD_VALUE - 9'(r_s2_cx));
        n    = (r_s2_cy >= r255) ? r_s2_cy - r255 : 8'(9'(r_s2_cy) + MOD_VALUE - 9'(r255));
        if (m == 8'd0 || (r_s2_xneg && m == 8'd1)) begin
            xb = X_ZERO_CODE;
        end else begin
            xb = m;
        end
        if (r_s2_ypos ? (n == MOD_TOP) : (n == 8'd0)) begin
            yb = Y_ZERO_CODE;
        end else begin
            yb = n + 8'd1;
        end
    end

    assign o_res_valid             = r_s2_v;
    assign o_res.verify_sum_a      = r_s2_sums.run_a;
    assign o_res.verify_sum_b      = r_s2_sums.run_b;
    assign o_res.verify_ok         = (r_s2_sums.run_a == 8'd0) && (r_s2_sums.run_b == 8'd0);
    assign o_res.check_value       = r_s2_sums.pos_err ? 16'd0 : {xb, yb};
    assign o_res.position_error    = r_s2_sums.pos_err;
endmodule

/* design/iso8473_fletcher_checksum.sv */
// Top level of the ISO 8473 Fletcher checksum block.
// Depends on fcs_pkg, fcs_front, fcs_fifo and fcs_back.
//
// Usage:
//   Input channel: one PDU byte per item with its first/last marks and the
//   checksum field position (sampled with the first byte). An item is taken
//   on a rising edge with push high and full low.
//   Result channel: one result item per last byte, carrying the verify sums,
//   the verify flag, the generated check value and the position error flag.
//   The oldest result is shown while empty is low and leaves on pop.
// Throughput: one byte per cycle while full is low, including back-to-back
//   one-byte PDUs; the byte update is two mod-255 adds per sum pair.
// Result path: a result becomes visible once its last byte has passed the
//   record queue, the multiply stage, the mod-255 fold stage and the output queue.
// Stalls: while results are not popped, the output queue fills, the back end
//   stops drawing PDU records, and once the record queue fills, full rises.
//   Bytes that do not end a PDU are still only taken while full is low.
// Reset: synchronous, active low. All sums, the byte count and the held
//   position clear, and both queues empty; results in flight are dropped.
module iso8473_fletcher_checksum import fcs_pkg::*; #(
    parameter int LENGTH_BITS = FCS_LENGTH_BITS,
    parameter int MID_DEPTH   = FCS_MID_DEPTH,
    parameter int OUT_DEPTH   = FCS_OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_check_position,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_verify_sum_a,
    output logic [7:0]  o_verify_sum_b,
    output logic        o_verify_ok,
    output logic [15:0] o_check_value,
    output logic        o_position_error
);
    localparam int RW = LENGTH_BITS + $bits(t_sums);

    logic                       accept;
    logic                       rec_push, rec_pop, mid_empty;
    t_sums                      rec_sums, mid_sums;
    logic [LENGTH_BITS-1:0]     rec_span, mid_span;
    logic [RW-1:0]              mid_out;
    logic                       res_valid, out_full;
    t_result                    res, out_res;
    logic [$clog2(OUT_DEPTH):0] out_count;

    assign accept = push && !full;

    fcs_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .i_check_position(i_check_position),
        .o_rec_push      (rec_push),
        .o_rec_sums      (rec_sums),
        .o_rec_span      (rec_span)
    );

    // Records of finished PDUs wait here for the back end.
    fcs_fifo #(
        .WIDTH(RW),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (rec_push),
        .i_data ({rec_span, rec_sums}),
        .i_pop  (rec_pop),
        .o_data (mid_out),
        .o_empty(mid_empty),
        .o_full (full),
        .o_count()
    );

    assign mid_span = mid_out[RW-1 -: LENGTH_BITS];
    assign mid_sums = mid_out[$bits(t_sums)-1:0];

    fcs_back #(
        .LENGTH_BITS(LENGTH_BITS),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec_valid(!mid_empty),
        .i_rec_sums (mid_sums),
        .i_rec_span (mid_span),
        .o_rec_pop  (rec_pop),
        .i_out_count(out_count),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // The back end only issues work it has room for, so out_full never
    // blocks a push; it is kept for completeness of the queue interface.
    fcs_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid && !out_full),
        .i_data (res),
        .i_pop  (pop),
        .o_data (out_res),
        .o_empty(empty),
        .o_full (out_full),
        .o_count(out_count)
    );

    assign o_verify_sum_a   = out_res.verify_sum_a;
    assign o_verify_sum_b   = out_res.verify_sum_b;
    assign o_verify_ok      = out_res.verify_ok;
    assign o_check_value    = out_res.check_value;
    assign o_position_error = out_res.position_error;
endmodule

/* design/fcs_checker.sv */
// Port-level checks for iso8473_fletcher_checksum, attached by bind.
// Depends only on the top level's ports.
module fcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_verify_sum_a,
    input logic [7:0]  o_verify_sum_b,
    input logic        o_verify_ok,
    input logic [15:0] o_check_value,
    input logic        o_position_error
);
    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A waiting result holds until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_check_value)
                              && $stable(o_verify_sum_a) && $stable(o_verify_sum_b)))
        else $error("stalled result changed");

    // A misplaced checksum field yields a zero check value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_position_error) |-> (o_check_value == 16'd0))
        else $error("check value not zero on position error");

    // The verify flag agrees with the verify sums, which stay below 255.
    a_verify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_verify_ok == (o_verify_sum_a == 8'd0 && o_verify_sum_b == 8'd0))
                    && o_verify_sum_a != 8'hFF && o_verify_sum_b != 8'hFF))
        else $error("verify fields inconsistent");

    // A generated check byte is never zero when the field fits.
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_position_error) |->
            (o_check_value[15:8] != 8'd0 && o_check_value[7:0] != 8'd0))
        else $error("zero check byte generated");
endmodule

bind iso8473_fletcher_checksum fcs_checker u_fcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_verify_sum_a  (o_verify_sum_a),
    .o_verify_sum_b  (o_verify_sum_b),
    .o_verify_ok     (o_verify_ok),
    .o_check_value   (o_check_value),
    .o_position_error(o_position_error)
);
